>>> hw/rtl/merge_insertion_sorter_unit_defines.svh
// ----------------------------------------------------------------------------
// Merge-insertion sorter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef MERGE_INSERTION_SORTER_UNIT_DEFINES_SVH
`define MERGE_INSERTION_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication
`define MSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/msu_pkg.sv
// ----------------------------------------------------------------------------
// Merge-insertion sorter package
// Widths, default capacity and the link and control types of the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msu_pkg;

  localparam int unsigned MSU_VALUE_W   = 32;
  localparam int unsigned MSU_MAX_ITEMS = 64;

  typedef logic signed [MSU_VALUE_W-1:0] msu_value_t;

  // What one cell shows its neighbours
  typedef struct packed {
    logic       occ;  // cell holds a value
    logic       lt;   // incoming word is below the held value
    msu_value_t val;
  } msu_link_t;

  // Row-wide commands
  typedef struct packed {
    logic ins;  // insert the incoming word
    logic shl;  // shift the row one cell towards the head
  } msu_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/msu_in_if.sv
// ----------------------------------------------------------------------------
// Merge-insertion sorter input channel
// Valid/ready channel carrying one value of a batch and its closing flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msu_in_if;
  import msu_pkg::*;

  logic       valid;
  logic       ready;
  msu_value_t value_in;
  logic       batch_end;

  modport source (output valid, output value_in, output batch_end, input ready);
  modport sink   (input valid, input value_in, input batch_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msu_out_if.sv
// ----------------------------------------------------------------------------
// Merge-insertion sorter output channel
// Valid/ready channel carrying one sorted value with its end and drop flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msu_out_if;
  import msu_pkg::*;

  logic       valid;
  logic       ready;
  msu_value_t value_out;
  logic       run_last;
  logic       overflow;

  modport source (output valid, output value_out, output run_last, output overflow,
                  input ready);
  modport sink   (input valid, input value_out, input run_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msu_cell.sv
// ----------------------------------------------------------------------------
// Merge-insertion sorter cell
// One slot of the sorted row: takes the incoming word, its left neighbour's
// value, or its right neighbour's value, so the row stays in ascending order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msu_cell
  import msu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire msu_ctrl_t  ctrl_i,
  input  wire msu_value_t new_val_i,
  input  wire msu_link_t  left_i,
  input  wire msu_link_t  right_i,
  output msu_link_t       link_o
);

  logic       occ_q, occ_d;
  msu_value_t val_q, val_d;
  logic       lt;

  // Compare the incoming word with the held one
  assign lt = occ_q && (new_val_i < val_q);

  // Pick the next content
  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (ctrl_i.shl) begin
      occ_d = right_i.occ;
      val_d = right_i.val;
    end else if (ctrl_i.ins) begin
      if (left_i.lt) begin
        // left neighbour is displaced into this slot
        occ_d = left_i.occ;
        val_d = left_i.val;
      end else if (left_i.occ && (!occ_q || lt)) begin
        // the incoming word lands here
        occ_d = 1'b1;
        val_d = new_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.occ = occ_q;
  assign link_o.lt  = lt;
  assign link_o.val = val_q;

endmodule

`default_nettype wire

>>> hw/rtl/merge_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// Merge-insertion sorter unit
// Batch sorter for signed 32-bit words built as a row of insertion cells.
//
//   Channel  Dir  Payload                         Moves
//   in_i     in   value_in, batch_end             one word per cycle while loading
//   out_o    out  value_out, run_last, overflow   one word per cycle while draining, if not stalled
//
// Loading inserts each word as it arrives: every cell compares the word at once
// and the row shifts right from the insertion point. The first sorted word is
// offered the cycle after batch_end is taken; a batch drains as the row shifts
// towards the head, during which the input is held off, so the next batch opens
// only after the final word has been taken. Words beyond MaxItems are dropped
// and flagged. Reset empties the row at once. A stalled output holds the row
// unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "merge_insertion_sorter_unit_defines.svh"

module merge_insertion_sorter_unit
  import msu_pkg::*;
#(
  parameter int unsigned MaxItems = MSU_MAX_ITEMS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msu_in_if.sink    in_i,
  msu_out_if.source out_o
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                state_q, state_d;
  logic                dropped_q, dropped_d;
  msu_ctrl_t           ctrl;
  msu_link_t           links [MaxItems];
  logic [MaxItems-1:0] occ;
  logic [MaxItems-1:0] occ_inc;
  logic                full;
  logic                in_acc;
  logic                out_acc;

  // Handshakes
  assign in_i.ready = (state_q == ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  assign full     = occ[MaxItems-1];
  assign ctrl.ins = in_acc && !full;
  assign ctrl.shl = out_acc;

  // Cell row
  for (genvar g = 0; g < MaxItems; g++) begin : g_cell
    msu_link_t left_link;
    msu_link_t right_link;

    if (g == 0) begin : g_head
      assign left_link = '{occ: 1'b1, lt: 1'b0, val: '0};
    end else begin : g_body
      assign left_link = links[g-1];
    end

    if (g == MaxItems - 1) begin : g_tail
      assign right_link = '{occ: 1'b0, lt: 1'b0, val: '0};
    end else begin : g_inner
      assign right_link = links[g+1];
    end

    msu_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_val_i (in_i.value_in),
      .left_i    (left_link),
      .right_i   (right_link),
      .link_o    (links[g])
    );

    assign occ[g] = links[g].occ;
  end

  // Sequence load and drain
  always_comb begin
    state_d   = state_q;
    dropped_d = dropped_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          dropped_d = dropped_q | full;
          if (in_i.batch_end) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_o.run_last) begin
          state_d   = ST_LOAD;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  // Head of the row is the output word
  assign out_o.valid     = (state_q == ST_DRAIN);
  assign out_o.value_out = links[0].val;
  assign out_o.run_last  = !links[1].occ;
  assign out_o.overflow  = dropped_q;

  assign occ_inc = occ + {{(MaxItems-1){1'b0}}, 1'b1};

  `MSU_ASSERT_NOW(a_row_packed, 1'b1, (occ & occ_inc) == '0, "row occupancy has a gap")
  `MSU_ASSERT_NOW(a_head_filled, out_o.valid, occ[0], "offering a word from an empty row")
  `MSU_ASSERT_NEXT(a_empty_after_last, out_acc && out_o.run_last, occ == '0,
                   "row not empty after final word")
  `MSU_ASSERT_NEXT(a_stall_holds, out_o.valid && !out_o.ready, $stable(occ),
                   "row moved while output stalled")

endmodule

`default_nettype wire
